@@ src/ttal_pkg.sv @@
`timescale 1ns / 1ps
// Package for the typed table address lookup: entry type codes, status codes,
// register indexes and the stored entry and result record types. No dependencies.
package ttal_pkg;

   localparam int TableDepthDefault = 1024;

   localparam logic [7:0] N_SO    = 8'h64;
   localparam logic [7:0] N_FUN   = 8'h24;
   localparam logic [7:0] N_SLINE = 8'h44;
   localparam logic [7:0] N_SOL   = 8'h84;
   localparam logic [7:0] N_PSYM  = 8'hA0;

   localparam logic [2:0] STATUS_FOUND   = 3'd0;
   localparam logic [2:0] STATUS_REFUSED = 3'd1;
   localparam logic [2:0] STATUS_BAD_STR = 3'd2;
   localparam logic [2:0] STATUS_NO_SRC  = 3'd3;
   localparam logic [2:0] STATUS_STORED  = 3'd4;

   localparam logic [1:0] CSR_ENTRY_COUNT = 2'd0;
   localparam logic [1:0] CSR_STR_SIZE    = 2'd1;
   localparam logic [1:0] CSR_STR_OK      = 2'd2;
   localparam logic [1:0] CSR_KERN_FLOOR  = 2'd3;

   localparam logic [31:0] KERNEL_FLOOR_RESET = 32'hEF80_0000;

   typedef struct packed {
      logic [7:0]  etype;
      logic [31:0] value;
      logic [15:0] desc;
      logic [31:0] stroff;
   } ttal_entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] line_number;
      logic        function_found;
      logic [31:0] function_address;
      logic [31:0] function_name_offset;
      logic        function_name_valid;
      logic [31:0] file_name_offset;
      logic        file_name_valid;
      logic [10:0] argument_count;
   } ttal_result_type;

endpackage

@@ src/ttal_req_if.sv @@
`timescale 1ns / 1ps
// Input channel of the typed table address lookup: valid, ready and one item.
// Depends on nothing.
interface ttal_req_if ();
   logic        valid;
   logic        ready;
   logic        mode;
   logic [9:0]  entry_index;
   logic [7:0]  entry_type;
   logic [31:0] entry_value;
   logic [15:0] entry_desc;
   logic [31:0] entry_string_offset;
   logic [31:0] lookup_address;

   modport source (output valid, mode, entry_index, entry_type, entry_value, entry_desc,
                   entry_string_offset, lookup_address, input ready);
   modport sink (input valid, mode, entry_index, entry_type, entry_value, entry_desc,
                 entry_string_offset, lookup_address, output ready);
endinterface

@@ src/ttal_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel of the typed table address lookup: valid, ready and one item.
// Depends on nothing.
interface ttal_rsp_if ();
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] line_number;
   logic        function_found;
   logic [31:0] function_address;
   logic [31:0] function_name_offset;
   logic        function_name_valid;
   logic [31:0] file_name_offset;
   logic        file_name_valid;
   logic [10:0] argument_count;

   modport source (output valid, status, line_number, function_found, function_address,
                   function_name_offset, function_name_valid, file_name_offset,
                   file_name_valid, argument_count, input ready);
   modport sink (input valid, status, line_number, function_found, function_address,
                 function_name_offset, function_name_valid, file_name_offset,
                 file_name_valid, argument_count, output ready);
endinterface

@@ src/ttal_table.sv @@
`timescale 1ns / 1ps
// Entry table of the typed table address lookup: one write port and one read
// port with registered read data. Depends on ttal_pkg.
module ttal_table import ttal_pkg::*; #(
   parameter int Depth = TableDepthDefault
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  ttal_entry_type           wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output ttal_entry_type           rd_data
);

   ttal_entry_type mem [Depth];
   ttal_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/typed_table_address_lookup_core.sv @@
`timescale 1ns / 1ps
// Typed table address lookup, top level. Depends on ttal_pkg, ttal_req_if,
// ttal_rsp_if and ttal_table.
// Stores, refused addresses and lookups with a bad string table give their result in the
// cycle after the item is taken. Other lookups run up to three bracketing searches (file,
// function, line) through the single registered read port, then walk back for the file
// name and count the parameters that follow the function entry.
// Only one item is in progress; a new item is taken the cycle after the result is taken.
// Synchronous reset clears the sequencer, the result valid and the configuration
// registers; the datapath registers and the table contents stay undefined.
module typed_table_address_lookup_core import ttal_pkg::*; #(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   ttal_req_if.sink    req,
   ttal_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = IW + 2;

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_LOOP     = 16'h0002,
      ST_SCAN_RD  = 16'h0004,
      ST_SCAN_CHK = 16'h0008,
      ST_FIN_RD   = 16'h0010,
      ST_FIN_CHK  = 16'h0020,
      ST_DONE     = 16'h0040,
      ST_FN_RD    = 16'h0080,
      ST_FN_CHK   = 16'h0100,
      ST_LN_RD    = 16'h0200,
      ST_LN_CHK   = 16'h0400,
      ST_WK_RD    = 16'h0800,
      ST_WK_CHK   = 16'h1000,
      ST_AR_INIT  = 16'h2000,
      ST_AR_RD    = 16'h4000,
      ST_AR_CHK   = 16'h8000
   } state_type;

   typedef enum logic [1:0] {
      PH_FILE = 2'd0,
      PH_FUN  = 2'd1,
      PH_LINE = 2'd2
   } phase_type;

   state_type       state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic            rsp_valid_ff, rsp_valid_in;
   ttal_result_type res_ff, res_in;

   logic signed [CW-1:0] l_ff, l_in, r_ff, r_in, lo_ff, lo_in, hi_ff, hi_in;
   logic signed [CW-1:0] mid_ff, mid_in, p_ff, p_in;
   logic signed [CW-1:0] lfile_ff, lfile_in, lfun_ff, lfun_in, rfun_ff, rfun_in;
   logic                 any_ff, any_in;
   logic [7:0]           want_ff, want_in;
   logic [31:0]          target_ff, target_in, addr_ff, addr_in;

   logic [10:0] entry_count_ff;
   logic [31:0] str_size_ff, floor_ff;
   logic        str_ok_ff;

   logic                 accept, csr_write, wr_en;
   logic signed [CW-1:0] n_entries;
   ttal_entry_type       wr_data, rd;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign n_entries = (32'(entry_count_ff) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                : CW'(entry_count_ff);
   assign wr_en     = accept && !req.mode && (32'(req.entry_index) < 32'(TABLE_DEPTH));
   assign wr_data   = '{etype: req.entry_type, value: req.entry_value,
                        desc: req.entry_desc, stroff: req.entry_string_offset};

   ttal_table #(.Depth(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IW'(req.entry_index)),
      .wr_data (wr_data),
      .rd_addr (p_ff[IW-1:0]),
      .rd_data (rd)
   );

   always_comb begin
      case (paddr[3:2])
         CSR_ENTRY_COUNT: prdata = 32'(entry_count_ff);
         CSR_STR_SIZE:    prdata = str_size_ff;
         CSR_STR_OK:      prdata = 32'(str_ok_ff);
         CSR_KERN_FLOOR:  prdata = floor_ff;
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         str_size_ff    <= '0;
         str_ok_ff      <= 1'b0;
         floor_ff       <= KERNEL_FLOOR_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            CSR_ENTRY_COUNT: entry_count_ff <= pwdata[10:0];
            CSR_STR_SIZE:    str_size_ff    <= pwdata;
            CSR_STR_OK:      str_ok_ff      <= pwdata[0];
            CSR_KERN_FLOOR:  floor_ff       <= pwdata;
            default:         ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      res_in       = res_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      p_in         = p_ff;
      lfile_in     = lfile_ff;
      lfun_in      = lfun_ff;
      rfun_in      = rfun_ff;
      any_in       = any_ff;
      want_in      = want_ff;
      target_in    = target_ff;
      addr_in      = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               if (!req.mode) begin
                  res_in.status = STATUS_STORED;
                  rsp_valid_in  = 1'b1;
               end else begin
                  res_in.function_address = req.lookup_address;
                  addr_in = req.lookup_address;
                  if (req.lookup_address < floor_ff) begin
                     res_in.status = STATUS_REFUSED;
                     rsp_valid_in  = 1'b1;
                  end else if (!str_ok_ff) begin
                     res_in.status = STATUS_BAD_STR;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     lo_in     = '0;
                     hi_in     = n_entries - CW'(1);
                     l_in      = '0;
                     r_in      = n_entries - CW'(1);
                     any_in    = 1'b0;
                     want_in   = N_SO;
                     target_in = req.lookup_address;
                     phase_in  = PH_FILE;
                     state_in  = ST_LOOP;
                  end
               end
            end
         end
         ST_LOOP: begin
            if (l_ff <= r_ff) begin
               mid_in   = (l_ff + r_ff) >>> 1;
               p_in     = (l_ff + r_ff) >>> 1;
               state_in = ST_SCAN_RD;
            end else if (!any_ff) begin
               hi_in    = lo_ff - CW'(1);
               state_in = ST_DONE;
            end else begin
               p_in     = hi_ff;
               state_in = ST_FIN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (p_ff < l_ff) begin
               l_in     = mid_ff + CW'(1);
               state_in = ST_LOOP;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (rd.etype != want_ff) begin
               p_in     = p_ff - CW'(1);
               state_in = ST_SCAN_RD;
            end else begin
               any_in   = 1'b1;
               state_in = ST_LOOP;
               if (rd.value < target_ff) begin
                  lo_in = p_ff;
                  l_in  = mid_ff + CW'(1);
               end else if (rd.value > target_ff) begin
                  hi_in = p_ff - CW'(1);
                  r_in  = p_ff - CW'(1);
               end else begin
                  lo_in     = p_ff;
                  l_in      = p_ff;
                  target_in = target_ff + 32'd1;
               end
            end
         end
         ST_FIN_RD: begin
            if (p_ff > lo_ff) begin
               state_in = ST_FIN_CHK;
            end else begin
               lo_in    = p_ff;
               state_in = ST_DONE;
            end
         end
         ST_FIN_CHK: begin
            if (rd.etype != want_ff) begin
               p_in     = p_ff - CW'(1);
               state_in = ST_FIN_RD;
            end else begin
               lo_in    = p_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            case (phase_ff)
               PH_FILE: begin
                  lfile_in = lo_ff;
                  if (lo_ff == '0) begin
                     res_in.status = STATUS_NO_SRC;
                     rsp_valid_in  = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     l_in      = lo_ff;
                     r_in      = hi_ff;
                     any_in    = 1'b0;
                     want_in   = N_FUN;
                     target_in = addr_ff;
                     phase_in  = PH_FUN;
                     state_in  = ST_LOOP;
                  end
               end
               PH_FUN: begin
                  lfun_in = lo_ff;
                  rfun_in = hi_ff;
                  if (lo_ff <= hi_ff) begin
                     res_in.function_found = 1'b1;
                     p_in     = lo_ff;
                     state_in = ST_FN_RD;
                  end else begin
                     p_in     = lfile_ff;
                     state_in = ST_WK_RD;
                  end
               end
               PH_LINE: begin
                  p_in     = lo_ff;
                  state_in = ST_LN_RD;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FN_RD: state_in = ST_FN_CHK;
         ST_FN_CHK: begin
            if (rd.stroff < str_size_ff) begin
               res_in.function_name_offset = rd.stroff;
               res_in.function_name_valid  = 1'b1;
            end
            res_in.function_address = rd.value;
            target_in = addr_ff - rd.value;
            l_in      = lo_ff;
            r_in      = hi_ff;
            any_in    = 1'b0;
            want_in   = N_SLINE;
            phase_in  = PH_LINE;
            state_in  = ST_LOOP;
         end
         ST_LN_RD: state_in = ST_LN_CHK;
         ST_LN_CHK: begin
            res_in.line_number = rd.desc;
            state_in = ST_WK_RD;
         end
         ST_WK_RD: begin
            state_in = (p_ff >= lfile_ff) ? ST_WK_CHK : ST_AR_INIT;
         end
         ST_WK_CHK: begin
            if (rd.etype == N_SOL || (rd.etype == N_SO && rd.value != '0)) begin
               if (rd.stroff < str_size_ff) begin
                  res_in.file_name_offset = rd.stroff;
                  res_in.file_name_valid  = 1'b1;
               end
               state_in = ST_AR_INIT;
            end else begin
               p_in     = p_ff - CW'(1);
               state_in = ST_WK_RD;
            end
         end
         ST_AR_INIT: begin
            if (lfun_ff < rfun_ff) begin
               p_in     = lfun_ff + CW'(1);
               state_in = ST_AR_RD;
            end else begin
               res_in.status = STATUS_FOUND;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_AR_RD: begin
            if (p_ff < rfun_ff) begin
               state_in = ST_AR_CHK;
            end else begin
               res_in.status = STATUS_FOUND;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_AR_CHK: begin
            if (rd.etype == N_PSYM) begin
               res_in.argument_count = res_ff.argument_count + 11'd1;
               p_in     = p_ff + CW'(1);
               state_in = ST_AR_RD;
            end else begin
               res_in.status = STATUS_FOUND;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FILE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff    <= res_in;
      l_ff      <= l_in;
      r_ff      <= r_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      p_ff      <= p_in;
      lfile_ff  <= lfile_in;
      lfun_ff   <= lfun_in;
      rfun_ff   <= rfun_in;
      any_ff    <= any_in;
      want_ff   <= want_in;
      target_ff <= target_in;
      addr_ff   <= addr_in;
   end

   assign rsp.valid                = rsp_valid_ff;
   assign rsp.status               = res_ff.status;
   assign rsp.line_number          = res_ff.line_number;
   assign rsp.function_found       = res_ff.function_found;
   assign rsp.function_address     = res_ff.function_address;
   assign rsp.function_name_offset = res_ff.function_name_offset;
   assign rsp.function_name_valid  = res_ff.function_name_valid;
   assign rsp.file_name_offset     = res_ff.file_name_offset;
   assign rsp.file_name_valid      = res_ff.file_name_valid;
   assign rsp.argument_count       = res_ff.argument_count;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("sequencer state is not one-hot");

   a_busy_no_result: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !rsp_valid_ff) else $error("result shown during a lookup");

   a_name_needs_function: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.function_name_valid |-> res_ff.function_found)
      else $error("function name valid without a function");

   a_lookup_starts_search: assert property (@(posedge clock) disable iff (reset)
      accept && req.mode && req.lookup_address >= floor_ff && str_ok_ff
      |=> state_ff == ST_LOOP && phase_ff == PH_FILE)
      else $error("accepted lookup did not start the file search");

endmodule

@@ sim/typed_table_address_lookup_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for typed_table_address_lookup_core: loads debug tables,
// runs lookups under random stalls and checks every result against its own predictor.
// Depends on ttal_pkg, ttal_req_if, ttal_rsp_if and the core itself.
module typed_table_address_lookup_core_test;
   import ttal_pkg::*;

   localparam int Depth = TableDepthDefault;
   localparam int CycleLimit = 4000000;

   typedef struct {
      bit        mode;
      bit [9:0]  idx;
      bit [7:0]  etype;
      bit [31:0] value;
      bit [15:0] desc;
      bit [31:0] stroff;
      bit [31:0] addr;
   } lookup_item_type;

   class lookup_scoreboard;
      bit [7:0]  etype_mem[Depth];
      bit [31:0] value_mem[Depth];
      bit [15:0] desc_mem[Depth];
      bit [31:0] stroff_mem[Depth];
      bit [10:0] entry_count;
      bit [31:0] str_size;
      bit        str_ok;
      bit [31:0] floor_addr;
      ttal_result_type expected_q[$];
      int        errors;

      function new();
         floor_addr = KERNEL_FLOOR_RESET;
      endfunction

      function void set_reg(logic [1:0] idx, bit [31:0] v);
         case (idx)
            CSR_ENTRY_COUNT: entry_count = v[10:0];
            CSR_STR_SIZE:    str_size = v;
            CSR_STR_OK:      str_ok = v[0];
            CSR_KERN_FLOOR:  floor_addr = v;
            default: ;
         endcase
      endfunction

      function void bracket(inout int lo, inout int hi, input bit [7:0] want,
                            input bit [31:0] target);
         int l, r, mid, m, k;
         bit any;
         l = lo;
         r = hi;
         any = 0;
         while (l <= r) begin
            mid = (l + r) / 2;
            m = mid;
            while (m >= l && etype_mem[m] != want) m--;
            if (m < l) begin
               l = mid + 1;
               continue;
            end
            any = 1;
            if (value_mem[m] < target) begin
               lo = m;
               l = mid + 1;
            end else if (value_mem[m] > target) begin
               hi = m - 1;
               r = m - 1;
            end else begin
               lo = m;
               l = m;
               target = target + 32'd1;
            end
         end
         if (!any) begin
            hi = lo - 1;
         end else begin
            k = hi;
            while (k > lo && etype_mem[k] != want) k--;
            lo = k;
         end
      endfunction

      function void note_item(lookup_item_type it);
         ttal_result_type res;
         int n, lfile, rfile, lfun, rfun, lline, rline, k;
         res = '0;
         if (!it.mode) begin
            etype_mem[it.idx] = it.etype;
            value_mem[it.idx] = it.value;
            desc_mem[it.idx] = it.desc;
            stroff_mem[it.idx] = it.stroff;
            res.status = STATUS_STORED;
            expected_q.push_back(res);
            return;
         end
         res.function_address = it.addr;
         if (it.addr < floor_addr) begin
            res.status = STATUS_REFUSED;
            expected_q.push_back(res);
            return;
         end
         if (!str_ok) begin
            res.status = STATUS_BAD_STR;
            expected_q.push_back(res);
            return;
         end
         n = (entry_count > Depth) ? Depth : entry_count;
         lfile = 0;
         rfile = n - 1;
         bracket(lfile, rfile, N_SO, it.addr);
         if (lfile == 0) begin
            res.status = STATUS_NO_SRC;
            expected_q.push_back(res);
            return;
         end
         lfun = lfile;
         rfun = rfile;
         bracket(lfun, rfun, N_FUN, it.addr);
         if (lfun <= rfun) begin
            res.function_found = 1;
            if (stroff_mem[lfun] < str_size) begin
               res.function_name_offset = stroff_mem[lfun];
               res.function_name_valid = 1;
            end
            res.function_address = value_mem[lfun];
            lline = lfun;
            rline = rfun;
            bracket(lline, rline, N_SLINE, it.addr - value_mem[lfun]);
            res.line_number = desc_mem[lline];
         end else begin
            lline = lfile;
         end
         while (lline >= lfile && etype_mem[lline] != N_SOL
                && (etype_mem[lline] != N_SO || value_mem[lline] == 0))
            lline--;
         if (lline >= lfile && stroff_mem[lline] < str_size) begin
            res.file_name_offset = stroff_mem[lline];
            res.file_name_valid = 1;
         end
         if (lfun < rfun)
            for (k = lfun + 1; k < rfun && etype_mem[k] == N_PSYM; k++)
               res.argument_count++;
         res.status = STATUS_FOUND;
         expected_q.push_back(res);
      endfunction

      function void compare(string name, bit [31:0] e, bit [31:0] a);
         if (e !== a) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(ttal_result_type act);
         ttal_result_type e;
         if (expected_q.size() == 0) begin
            $error("Result arrived with no item outstanding");
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare("status", 32'(e.status), 32'(act.status));
         compare("line_number", 32'(e.line_number), 32'(act.line_number));
         compare("function_found", 32'(e.function_found), 32'(act.function_found));
         compare("function_address", e.function_address, act.function_address);
         compare("function_name_offset", e.function_name_offset, act.function_name_offset);
         compare("function_name_valid", 32'(e.function_name_valid),
                 32'(act.function_name_valid));
         compare("file_name_offset", e.file_name_offset, act.file_name_offset);
         compare("file_name_valid", 32'(e.file_name_valid), 32'(act.file_name_valid));
         compare("argument_count", 32'(e.argument_count), 32'(act.argument_count));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   ttal_req_if req_ch ();
   ttal_rsp_if rsp_ch ();

   typed_table_address_lookup_core dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   lookup_scoreboard sb = new();
   int send_idle;
   int recv_idle;
   int item_total;
   int filled;
   int cycles;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      ttal_result_type act;
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= recv_idle);
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready && !reset) begin
            act.status = rsp_ch.status;
            act.line_number = rsp_ch.line_number;
            act.function_found = rsp_ch.function_found;
            act.function_address = rsp_ch.function_address;
            act.function_name_offset = rsp_ch.function_name_offset;
            act.function_name_valid = rsp_ch.function_name_valid;
            act.file_name_offset = rsp_ch.file_name_offset;
            act.file_name_valid = rsp_ch.file_name_valid;
            act.argument_count = rsp_ch.argument_count;
            sb.check_result(act);
         end
      end
   end

   task automatic send_item(lookup_item_type it);
      forever begin
         @(negedge clock);
         if ($urandom_range(99) < send_idle) begin
            req_ch.valid = 0;
         end else begin
            break;
         end
      end
      req_ch.valid = 1;
      req_ch.mode = it.mode;
      req_ch.entry_index = it.idx;
      req_ch.entry_type = it.etype;
      req_ch.entry_value = it.value;
      req_ch.entry_desc = it.desc;
      req_ch.entry_string_offset = it.stroff;
      req_ch.lookup_address = it.addr;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(it);
      item_total++;
      if (item_total < 200) begin
         send_idle = 14;
         recv_idle = 56;
      end else if (item_total < 400) begin
         send_idle = 56;
         recv_idle = 14;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, bit [31:0] v);
      @(negedge clock);
      psel = 1;
      penable = 0;
      pwrite = 1;
      paddr = {idx, 2'b00};
      pwdata = v;
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, v);
      @(negedge clock);
      psel = 0;
      penable = 0;
   endtask

   task automatic store(int idx, bit [7:0] t, bit [31:0] v, bit [15:0] d, bit [31:0] s);
      lookup_item_type it;
      it = '{1'b0, idx[9:0], t, v, d, s, $urandom};
      send_item(it);
      if (idx == filled) filled++;
   endtask

   task automatic lookup(bit [31:0] a);
      lookup_item_type it;
      it = '{1'b1, 10'($urandom), 8'($urandom), $urandom, 16'($urandom), $urandom, a};
      send_item(it);
   endtask

   function automatic bit [31:0] pick_offset(bit [31:0] size);
      if ($urandom_range(1) && size != 0) return $urandom_range(size - 1, 0);
      return $urandom;
   endfunction

   // Builds a plausible table in slots 0 to n-1: files and functions at a rising address
   // that may wrap, parameters at random places, line offsets relative to the function start.
   task automatic load_table(int n, bit [31:0] base, bit [31:0] size);
      bit [31:0] cur, fstart, v;
      bit [7:0]  t;
      int roll;
      cur = base;
      fstart = base;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (i == 1 || roll < 14) begin
            t = N_SO;
            v = ($urandom_range(9) == 0) ? 32'd0 : cur;
         end else if (roll < 34) begin
            t = N_FUN;
            v = cur;
            fstart = cur;
         end else if (roll < 48) begin
            t = N_PSYM;
            v = $urandom;
         end else if (roll < 78) begin
            t = N_SLINE;
            v = cur - fstart;
         end else if (roll < 85) begin
            t = N_SOL;
            v = cur;
         end else begin
            t = 8'($urandom);
            v = $urandom;
         end
         if (i == 0 && $urandom_range(1)) t = 8'($urandom);
         store(i, t, v, 16'($urandom), pick_offset(size));
         cur = cur + $urandom_range(24, 0);
      end
   endtask

   task automatic run_phase(int n, int lookups, int count_val);
      bit [31:0] base, size, fl, a;
      int roll;
      base = $urandom_range(3) == 0 ? 32'hFFFF_F000 + $urandom_range(1024) : $urandom;
      roll = $urandom_range(9);
      size = roll == 0 ? 32'd0 : roll == 1 ? 32'hFFFF_FFFF : $urandom_range(4096);
      load_table(n, base, size);
      wait_idle();
      roll = $urandom_range(9);
      fl = roll == 0 ? 32'd0 : roll == 1 ? 32'hFFFF_FFFF : roll == 2 ? $urandom
         : (base > 200 ? base - $urandom_range(200) : 32'd0);
      write_reg(CSR_ENTRY_COUNT, 32'(count_val));
      write_reg(CSR_STR_SIZE, size);
      write_reg(CSR_STR_OK, 32'($urandom_range(15) != 0));
      write_reg(CSR_KERN_FLOOR, fl);
      for (int i = 0; i < lookups; i++) begin
         roll = $urandom_range(99);
         if (roll < 75) a = base + $urandom_range(n * 24 + 40);
         else if (roll < 85) a = sb.value_mem[$urandom_range(n - 1)];
         else if (roll < 90) a = fl - 1;
         else a = $urandom;
         lookup(a);
      end
      wait_idle();
   endtask

   initial begin
      int n;
      send_idle = 14;
      recv_idle = 56;
      item_total = 0;
      filled = 0;
      reset = 1;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 0;
      req_ch.mode = 0;
      req_ch.entry_index = '0;
      req_ch.entry_type = '0;
      req_ch.entry_value = '0;
      req_ch.entry_desc = '0;
      req_ch.entry_string_offset = '0;
      req_ch.lookup_address = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      lookup(32'd0);
      lookup(32'hEF7F_FFFF);
      lookup(32'hEF80_0000);
      lookup(32'hFFFF_FFFF);
      wait_idle();
      write_reg(CSR_STR_OK, 1);
      lookup(32'hF000_0000);
      store(0, 8'h00, 32'h0, 16'd0, 32'd0);
      store(1, N_SO, 32'hF000_0000, 16'd0, 32'd1);
      store(2, N_FUN, 32'hF000_0010, 16'd7, 32'd2);
      store(3, N_PSYM, 32'd4, 16'd0, 32'd0);
      store(4, N_PSYM, 32'd8, 16'd0, 32'd0);
      store(5, N_SLINE, 32'd0, 16'd10, 32'd0);
      store(6, N_SLINE, 32'd8, 16'd11, 32'd0);
      store(7, N_SOL, 32'hF000_0020, 16'd0, 32'd3);
      store(8, N_SLINE, 32'h10, 16'd12, 32'd0);
      store(9, N_FUN, 32'hFFFF_FFFF, 16'hFFFF, 32'd50);
      wait_idle();
      write_reg(CSR_ENTRY_COUNT, 10);
      write_reg(CSR_STR_SIZE, 10);
      write_reg(CSR_KERN_FLOOR, 32'hF000_0000);
      lookup(32'hF000_0000);
      lookup(32'hF000_0010);
      lookup(32'hF000_0018);
      lookup(32'hF000_0030);
      lookup(32'hFFFF_FFFF);
      wait_idle();

      while (item_total < 200) begin
         n = $urandom_range(48, 2);
         run_phase(n, $urandom_range(40, 15),
                   $urandom_range(3) == 0 ? $urandom_range(filled) : n);
         if (item_total > 100 && item_total < 140) wait_idle();
      end

      run_phase(Depth, 12, Depth);
      write_reg(CSR_ENTRY_COUNT, 32'h7FF);
      for (int i = 0; i < 8; i++) lookup(sb.value_mem[$urandom_range(Depth - 1)] + 1);
      wait_idle();
      write_reg(CSR_ENTRY_COUNT, 0);
      lookup(32'hFFFF_FFFF);
      wait_idle();

      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ typed_table_address_lookup_core.f @@
src/ttal_pkg.sv
src/ttal_req_if.sv
src/ttal_rsp_if.sv
src/ttal_table.sv
src/typed_table_address_lookup_core.sv
sim/typed_table_address_lookup_core_test.sv
